// ===== hdl/cue_pkg.sv =====
// Shared types, constants and a helper function for the cookie uid extractor.
package cue_pkg;

    localparam int NAME_BYTES  = 8;
    localparam int UID_CHARS   = 22;
    localparam int UID_BYTES   = 16;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 136;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 64;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_NAME_LEN = 2'd1;
    localparam logic [1:0] REG_NAME     = 2'd2;

    localparam logic [3:0] NAME_LEN_RESET = 4'd3;
    localparam logic [63:0] NAME_RESET    = 64'h0000_0000_0064_6975;

    typedef enum logic [6:0] {
        PH_NAME      = 7'b0000001,
        PH_SKIP_SEMI = 7'b0000010,
        PH_SKIP_SP   = 7'b0000100,
        PH_SP_EQ     = 7'b0001000,
        PH_SP_VAL    = 7'b0010000,
        PH_VALUE     = 7'b0100000,
        PH_DONE      = 7'b1000000
    } phase_t;

    typedef enum logic [2:0] {
        ST_FOUND   = 3'd0,
        ST_NOMATCH = 3'd1,
        ST_SHORT   = 3'd2,
        ST_INVALID = 3'd3,
        ST_NOEQ    = 3'd4
    } status_t;

    typedef struct packed {
        logic                            enable;
        logic [3:0]                      name_len;
        logic [NAME_BYTES-1:0][7:0]      name_bytes;
    } cfg_t;

    typedef struct packed {
        logic              got;
        logic [3:0][31:0]  words;
        status_t           status;
    } res_t;

    // Bit 6 set means the character is outside the standard alphabet.
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c >= "A" && c <= "Z") begin
            v = {1'b0, 6'(c - 8'h41)};
        end else if (c >= "a" && c <= "z") begin
            v = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= "0" && c <= "9") begin
            v = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == "+") begin
            v = 7'd62;
        end else if (c == "/") begin
            v = 7'd63;
        end
        return v;
    endfunction

endpackage

// ===== hdl/cue_regs.sv =====
// Configuration register file behind the APB-style port.
module cue_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cue_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cue_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cue_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output cue_pkg::cfg_t                 cfg
);
    import cue_pkg::*;

    logic        enable_reg;
    logic [3:0]  name_len_reg;
    logic [63:0] name_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            name_len_reg <= NAME_LEN_RESET;
            name_reg     <= NAME_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_ENABLE:   enable_reg   <= pwdata[0];
                REG_NAME_LEN: name_len_reg <= pwdata[3:0];
                REG_NAME:     name_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ENABLE:   prdata = {63'd0, enable_reg};
            REG_NAME_LEN: prdata = {60'd0, name_len_reg};
            REG_NAME:     prdata = name_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.enable     = enable_reg;
    assign cfg.name_len   = name_len_reg;
    assign cfg.name_bytes = name_reg;

endmodule

// ===== hdl/cue_scan.sv =====
// Scan state, name match and base64 decode, updated once per accepted beat.
module cue_scan (
    input  logic          aclk,
    input  logic          aresetn,
    input  cue_pkg::cfg_t cfg,
    input  logic          beat,
    input  logic [7:0]    data_byte,
    input  logic [12:0]   header_length,
    input  logic          last_in_header,
    input  logic          new_request,
    output cue_pkg::res_t res
);
    import cue_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic        miss_reg, miss_next;
    logic        ignored_reg, ignored_next;
    logic        req_done_reg, req_done_next;
    logic        invalid_reg, invalid_next;
    logic        pad_reg, pad_next;
    logic [5:0]  carry_reg, carry_next;
    logic        hdr_start_reg;
    logic [UID_BYTES-1:0][7:0] store_reg, store_next;

    logic        hdr_start;
    logic        active;
    logic        got;
    status_t     status;
    logic [3:0]  eff_len;
    logic [6:0]  b64;
    logic [4:0]  k;
    logic [6:0]  bit_pos;
    logic [7:0]  dec_byte;
    logic        dec_write;

    assign eff_len   = (cfg.name_len > 4'(NAME_BYTES)) ? 4'(NAME_BYTES) : cfg.name_len;
    assign hdr_start = hdr_start_reg || new_request;
    assign b64       = b64_value(data_byte);

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        miss_next     = miss_reg;
        ignored_next  = ignored_reg;
        req_done_next = new_request ? 1'b0 : req_done_reg;
        invalid_next  = invalid_reg;
        pad_next      = pad_reg;
        carry_next    = carry_reg;
        store_next    = store_reg;
        got           = 1'b0;
        status        = ST_FOUND;
        k             = '0;
        bit_pos       = '0;
        dec_byte      = '0;
        dec_write     = 1'b0;

        if (hdr_start) begin
            phase_next   = PH_NAME;
            pos_next     = '0;
            miss_next    = 1'b0;
            ignored_next = {9'd0, eff_len} >= header_length;
        end

        active = cfg.enable && !req_done_next && (phase_next != PH_DONE);

        if (active && !ignored_next) begin
            if (phase_next == PH_SKIP_SP && data_byte != CH_SPACE) begin
                phase_next = PH_NAME;
                pos_next   = '0;
                miss_next  = 1'b0;
            end
            if (phase_next == PH_NAME && eff_len == 4'd0) begin
                phase_next = PH_SP_EQ;
            end
            if (phase_next == PH_SP_VAL && data_byte != CH_SPACE) begin
                phase_next   = PH_VALUE;
                pos_next     = '0;
                invalid_next = 1'b0;
                pad_next     = 1'b0;
                carry_next   = '0;
                store_next   = '0;
            end

            case (phase_next)
                PH_SKIP_SEMI: begin
                    if (data_byte == CH_SEMI) begin
                        phase_next = PH_SKIP_SP;
                    end
                end
                PH_NAME: begin
                    if (pos_next < 5'(NAME_BYTES) &&
                        cfg.name_bytes[pos_next[2:0]] != data_byte) begin
                        miss_next = 1'b1;
                    end
                    pos_next = pos_next + 5'd1;
                    if (pos_next >= {1'b0, eff_len}) begin
                        phase_next = miss_next ? PH_SKIP_SEMI : PH_SP_EQ;
                    end
                end
                PH_SP_EQ: begin
                    if (data_byte == CH_EQ) begin
                        phase_next = PH_SP_VAL;
                    end else if (data_byte != CH_SPACE) begin
                        status     = ST_NOEQ;
                        phase_next = PH_DONE;
                        got        = 1'b1;
                    end
                end
                PH_VALUE: begin
                    if (data_byte == CH_SEMI) begin
                        status     = ST_SHORT;
                        phase_next = PH_DONE;
                        got        = 1'b1;
                    end else begin
                        k       = pos_next;
                        bit_pos = {k, 2'b00} + {1'b0, k, 1'b0};
                        if (!pad_next) begin
                            if (data_byte == CH_EQ) begin
                                pad_next = 1'b1;
                                if (k[1:0] == 2'd1) begin
                                    invalid_next = 1'b1;
                                end
                            end else if (b64[6]) begin
                                invalid_next = 1'b1;
                            end else if (!invalid_next) begin
                                case (k[1:0])
                                    2'd0: begin
                                        carry_next = b64[5:0];
                                    end
                                    2'd1: begin
                                        dec_byte   = {carry_next[5:0], b64[5:4]};
                                        dec_write  = 1'b1;
                                        carry_next = {2'b00, b64[3:0]};
                                    end
                                    2'd2: begin
                                        dec_byte   = {carry_next[3:0], b64[5:2]};
                                        dec_write  = 1'b1;
                                        carry_next = {4'b0000, b64[1:0]};
                                    end
                                    default: begin
                                        dec_byte   = {carry_next[1:0], b64[5:0]};
                                        dec_write  = 1'b1;
                                        carry_next = '0;
                                    end
                                endcase
                                if (dec_write) begin
                                    store_next[bit_pos[6:3]] = dec_byte;
                                end
                            end
                        end
                        pos_next = pos_next + 5'd1;
                        if (pos_next >= 5'(UID_CHARS)) begin
                            phase_next = PH_DONE;
                            got        = 1'b1;
                            if (invalid_next) begin
                                status = ST_INVALID;
                            end else begin
                                status        = ST_FOUND;
                                req_done_next = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (!got && last_in_header && active) begin
            if (ignored_next) begin
                status = ST_NOMATCH;
            end else if (phase_next == PH_SP_EQ) begin
                status = ST_NOEQ;
            end else if (phase_next == PH_SP_VAL || phase_next == PH_VALUE) begin
                status = ST_SHORT;
            end else begin
                status = ST_NOMATCH;
            end
            phase_next = PH_DONE;
            got        = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_NAME;
            pos_reg       <= '0;
            miss_reg      <= 1'b0;
            ignored_reg   <= 1'b0;
            req_done_reg  <= 1'b0;
            invalid_reg   <= 1'b0;
            pad_reg       <= 1'b0;
            carry_reg     <= '0;
            hdr_start_reg <= 1'b1;
        end else if (beat) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            miss_reg      <= miss_next;
            ignored_reg   <= ignored_next;
            req_done_reg  <= req_done_next;
            invalid_reg   <= invalid_next;
            pad_reg       <= pad_next;
            carry_reg     <= carry_next;
            hdr_start_reg <= last_in_header;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat) begin
            store_reg <= store_next;
        end
    end

    assign res.got    = got;
    assign res.status = status;
    assign res.words  = (status == ST_FOUND) ? store_next : '0;

endmodule

// ===== hdl/cookie_uid_extractor.sv =====
// Top level of the cookie uid extractor: stream ports, registers and result stage.
// The block takes one cookie header byte per clock and answers with at most one
// result beat per input beat, in the cycle after the input beat that decides it.
// Each byte is handled by a single pass through the scan logic into the result
// register, so a sustained rate of one byte per cycle holds; s_tready drops only
// while a result sits in the output register and m_tready is low. Configuration
// must be written through the APB port only while the block is idle (unenforced).
module cookie_uid_extractor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // data_byte [7:0], header_length [20:8], zero fill [23:21]
    input  logic [cue_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    // new_request
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // uid_word0 [31:0], uid_word1 [63:32], uid_word2 [95:64],
    // uid_word3 [127:96], status [130:128], zero fill [135:131]
    output logic [cue_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cue_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cue_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cue_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import cue_pkg::*;

    cfg_t                  cfg;
    res_t                  res;
    logic                  beat;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign beat     = s_tvalid && s_tready;

    cue_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cue_scan u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .beat           (beat),
        .data_byte      (s_tdata[7:0]),
        .header_length  (s_tdata[20:8]),
        .last_in_header (s_tlast),
        .new_request    (s_tuser),
        .res            (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= beat && res.got;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat && res.got) begin
            m_tdata_reg <= {5'd0, res.status, res.words};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/cue_checker.sv =====
// Port-level assertions for the cookie uid extractor and their bind.
module cue_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cue_pkg::M_TDATA_W-1:0] m_tdata
);
    import cue_pkg::*;

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result beat changed while stalled.");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[130:128] <= 3'(ST_NOEQ)) && (m_tdata[135:131] == 5'd0))
        else $error("Result status out of range.");

    a_uid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[130:128] != 3'(ST_FOUND)) |-> (m_tdata[127:0] == '0))
        else $error("Uid words set on a result without a uid.");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("Input stalled while the result stage could move.");

    a_no_result_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("Result beat appeared without an input beat.");

endmodule

bind cookie_uid_extractor cue_checker u_cue_checker (.*);
